// ===== rtl/ps2hpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hpc_pkg
// Shared types, codes and constants for the PS/2 host port controller.
// ----------------------------------------------------------------------------
package ps2hpc_pkg;

    // Width of the bit timer; the counter saturates at its all-ones value
    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_READ_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_WRITE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_INHIBIT_HOLD  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_BITS-1:0] READ_TIMEOUT_RST  = 16'd50;
    localparam logic [CFG_BITS-1:0] WRITE_TIMEOUT_RST = 16'd2000;
    localparam logic [CFG_BITS-1:0] INHIBIT_HOLD_RST  = 16'd120;

    // Event kinds carried on the input beat
    typedef enum logic [1:0] {
        FUNC_EDGE  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_WRITE = 2'd2
    } func_t;

    // Link modes
    typedef enum logic [1:0] {
        MODE_READ    = 2'd0,
        MODE_INHIBIT = 2'd1,
        MODE_WRITE   = 2'd2
    } mode_t;

    // Receive error codes
    typedef enum logic [2:0] {
        RXE_NONE    = 3'd0,
        RXE_START   = 3'd1,
        RXE_PARITY  = 3'd2,
        RXE_STOP    = 3'd3,
        RXE_TIMEOUT = 3'd4
    } rx_err_t;

    // Transmit status codes
    typedef enum logic [1:0] {
        TXS_NONE   = 2'd0,
        TXS_ACKED  = 2'd1,
        TXS_FAILED = 2'd2,
        TXS_BUSY   = 2'd3
    } tx_stat_t;

    // Bit positions of the stop slot and the final (acknowledge) slot in a host write
    localparam logic [3:0] POS_STOP = 4'd10;
    localparam logic [3:0] POS_ACK  = 4'd11;

    // Link state carried between beats
    typedef struct packed {
        mode_t                  mode;
        logic [3:0]             bit_pos;
        logic [7:0]             rx_shift;
        logic [10:0]            tx_frame;
        logic [TIMER_BITS-1:0]  tick_count;
        logic                   timer_armed;
        logic                   clock_drive;
        logic                   data_drive;
    } link_state_t;

    // Timer limits from the configuration registers
    typedef struct packed {
        logic [CFG_BITS-1:0] read_timeout;
        logic [CFG_BITS-1:0] write_timeout;
        logic [CFG_BITS-1:0] inhibit_hold;
    } cfg_t;

    // One result beat
    typedef struct packed {
        tx_stat_t   tx_status;
        rx_err_t    rx_error;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       data_pull_low;
        logic       clock_pull_low;
    } result_t;

endpackage

// ===== rtl/ps2_host_port_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_host_port_controller_core
// Host side of a PS/2 link driven by edge, tick and write-request events.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  s_       in   one event: kind in tuser, data line and write byte in tdata
//  m_       out  one result per event: line drives, rx byte/error, tx status
//  cfg_     in   timer register writes, index 0..2, no read-back
//
//  Each event is taken at the accepting edge, where the link state and the
//  result register are updated together, one beat per cycle while m_tready is high.
//  A result waits in the output register while the next event is taken in
//  the same cycle it leaves; s_tready falls only while it is held unread.
//  Synchronous active-low reset puts the link in read mode with both lines
//  released and loads the default timer limits.
// ----------------------------------------------------------------------------
module ps2_host_port_controller_core
    import ps2hpc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [0] data_line, [8:1] tx_byte, rest zero
    input  logic [1:0]          s_tuser,   // [1:0] func

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [0] clock_pull_low, [1] data_pull_low,
                                           // [2] rx_valid, [10:3] rx_byte,
                                           // [13:11] rx_error, [15:14] tx_status

    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata
);

    cfg_t        cfg_reg;
    link_state_t state_reg;
    link_state_t state_next;
    result_t     res_reg;
    result_t     res_next;
    logic        m_valid_reg;
    logic        accept;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.read_timeout  <= READ_TIMEOUT_RST;
            cfg_reg.write_timeout <= WRITE_TIMEOUT_RST;
            cfg_reg.inhibit_hold  <= INHIBIT_HOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_READ_TIMEOUT:  cfg_reg.read_timeout  <= cfg_wdata;
                REG_WRITE_TIMEOUT: cfg_reg.write_timeout <= cfg_wdata;
                REG_INHIBIT_HOLD:  cfg_reg.inhibit_hold  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Handshake: take a beat whenever the result slot is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ps2hpc_step u_step (
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .func      (s_tuser),
        .data_line (s_tdata[0]),
        .tx_byte   (s_tdata[8:1]),
        .nxt       (state_next),
        .res       (res_next)
    );

    // Link state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

    // Checks
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bit_pos <= POS_ACK)
        else $error("bit position beyond ack slot");

    a_read_released: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode == MODE_READ |-> !state_reg.clock_drive && !state_reg.data_drive)
        else $error("line driven in read mode");

    a_inhibit_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode == MODE_INHIBIT |-> state_reg.clock_drive && state_reg.timer_armed)
        else $error("inhibit without clock held low");

    a_rx_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.rx_valid |-> res_reg.rx_error == RXE_NONE)
        else $error("byte reported together with an error");

    a_drive_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> res_reg.clock_pull_low == state_reg.clock_drive
                   && res_reg.data_pull_low == state_reg.data_drive)
        else $error("reported drives differ from link state");

endmodule

// ===== rtl/ps2hpc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hpc_step
// Next-state and result logic for one event: receive deframing, inhibit
// timing and host write shifting.
// ----------------------------------------------------------------------------
module ps2hpc_step
    import ps2hpc_pkg::*;
(
    input  link_state_t cur,
    input  cfg_t        cfg,
    input  logic [1:0]  func,
    input  logic        data_line,
    input  logic [7:0]  tx_byte,
    output link_state_t nxt,
    output result_t     res
);

    logic [TIMER_BITS-1:0] tick_inc;
    logic [TIMER_BITS-1:0] limit;
    logic                  expired;
    logic [2:0]            rx_idx;

    // Saturating tick count and the limit of the current mode
    always_comb begin
        tick_inc = (&cur.tick_count) ? cur.tick_count : cur.tick_count + 1'b1;
        unique case (cur.mode)
            MODE_READ:    limit = TIMER_BITS'(cfg.read_timeout);
            MODE_INHIBIT: limit = TIMER_BITS'(cfg.inhibit_hold);
            default:      limit = TIMER_BITS'(cfg.write_timeout);
        endcase
        expired = cur.timer_armed && (tick_inc >= limit);
        rx_idx  = 3'(cur.bit_pos - 4'd1);
    end

    always_comb begin
        nxt = cur;
        res = '0;

        unique case (func)
            // Device clock falling edge
            FUNC_EDGE: begin
                if (cur.mode == MODE_READ) begin
                    nxt.timer_armed = 1'b0;
                    nxt.tick_count  = '0;
                    if (cur.bit_pos == 4'd0) begin
                        if (data_line) begin
                            res.rx_error  = RXE_START;
                            nxt.rx_shift  = '0;
                        end else begin
                            nxt.bit_pos     = 4'd1;
                            nxt.timer_armed = 1'b1;
                        end
                    end else if (cur.bit_pos <= 4'd8) begin
                        nxt.rx_shift[rx_idx] = cur.rx_shift[rx_idx] | data_line;
                        nxt.bit_pos          = cur.bit_pos + 4'd1;
                        nxt.timer_armed      = 1'b1;
                    end else if (cur.bit_pos == 4'd9) begin
                        // odd parity over data and parity bit
                        if (!((^cur.rx_shift) ^ data_line)) begin
                            res.rx_error = RXE_PARITY;
                            nxt.bit_pos  = '0;
                            nxt.rx_shift = '0;
                        end else begin
                            nxt.bit_pos     = POS_STOP;
                            nxt.timer_armed = 1'b1;
                        end
                    end else begin
                        if (cur.bit_pos == POS_STOP) begin
                            if (data_line) begin
                                res.rx_valid = 1'b1;
                                res.rx_byte  = cur.rx_shift;
                            end else begin
                                res.rx_error = RXE_STOP;
                            end
                        end
                        nxt.bit_pos  = '0;
                        nxt.rx_shift = '0;
                    end
                end else if (cur.mode == MODE_WRITE) begin
                    if (cur.bit_pos >= 4'd1 && cur.bit_pos <= POS_STOP) begin
                        nxt.data_drive  = ~cur.tx_frame[cur.bit_pos];
                        nxt.bit_pos     = cur.bit_pos + 4'd1;
                        nxt.tick_count  = '0;
                        nxt.timer_armed = 1'b1;
                    end else begin
                        // ack slot: device pulls data low
                        if (cur.bit_pos == POS_ACK && !data_line) begin
                            res.tx_status = TXS_ACKED;
                        end else begin
                            res.tx_status = TXS_FAILED;
                        end
                        nxt = '0;
                    end
                end
            end

            // Time tick
            FUNC_TICK: begin
                if (cur.timer_armed) begin
                    nxt.tick_count = tick_inc;
                end
                if (expired) begin
                    unique case (cur.mode)
                        MODE_READ: begin
                            res.rx_error    = RXE_TIMEOUT;
                            nxt.bit_pos     = '0;
                            nxt.rx_shift    = '0;
                            nxt.timer_armed = 1'b0;
                            nxt.tick_count  = '0;
                        end
                        MODE_INHIBIT: begin
                            // start bit on data, release clock
                            nxt.data_drive  = 1'b1;
                            nxt.clock_drive = 1'b0;
                            nxt.mode        = MODE_WRITE;
                            nxt.bit_pos     = 4'd1;
                            nxt.tick_count  = '0;
                            nxt.timer_armed = 1'b1;
                        end
                        default: begin
                            res.tx_status = TXS_FAILED;
                            nxt           = '0;
                        end
                    endcase
                end
            end

            // Host write request
            FUNC_WRITE: begin
                if (cur.mode != MODE_READ) begin
                    res.tx_status = TXS_BUSY;
                end else begin
                    nxt.tx_frame    = {1'b1, ~(^tx_byte), tx_byte, 1'b0};
                    nxt.bit_pos     = '0;
                    nxt.rx_shift    = '0;
                    nxt.mode        = MODE_INHIBIT;
                    nxt.clock_drive = 1'b1;
                    nxt.data_drive  = 1'b0;
                    nxt.tick_count  = '0;
                    nxt.timer_armed = 1'b1;
                end
            end

            // unused code: nothing changes
            default: begin
            end
        endcase

        res.clock_pull_low = nxt.clock_drive;
        res.data_pull_low  = nxt.data_drive;
    end

endmodule

// ===== tb/ps2hpc_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hpc_response_checker
// Watches the event, response and register ports of the PS/2 host port
// controller, predicts every response beat from its own copy of the link
// state and timer limits, and compares the block's beats field by field.
// ----------------------------------------------------------------------------
module ps2hpc_response_checker
    import ps2hpc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [15:0]         s_tdata,   // [0] data_line, [8:1] tx_byte, rest zero
    input  logic [1:0]          s_tuser,   // [1:0] func

    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [15:0]         m_tdata,   // [0] clock_pull_low, [1] data_pull_low,
                                           // [2] rx_valid, [10:3] rx_byte,
                                           // [13:11] rx_error, [15:14] tx_status

    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata,

    output int                  mismatches,
    output int                  responses_due
);

    localparam logic [3:0] PARITY_POS = 4'd9;

    // counters start at zero as two-state variables
    link_state_t link;
    cfg_t        timers;
    result_t     due_responses[$];
    int          response_count;

    // ---- link model helpers ----
    function automatic void arm_timer();
        link.tick_count  = '0;
        link.timer_armed = 1'b1;
    endfunction

    function automatic void drop_frame();
        link.bit_pos     = '0;
        link.rx_shift    = '0;
        link.timer_armed = 1'b0;
        link.tick_count  = '0;
    endfunction

    function automatic void end_write();
        drop_frame();
        link.mode        = MODE_READ;
        link.tx_frame    = '0;
        link.clock_drive = 1'b0;
        link.data_drive  = 1'b0;
    endfunction

    // One tick of the bit timer; counter saturates at all ones
    function automatic logic timer_expires(logic [CFG_BITS-1:0] limit);
        if (!link.timer_armed)
            return 1'b0;
        if (link.tick_count != '1)
            link.tick_count = link.tick_count + 1'b1;
        return link.tick_count >= limit;
    endfunction

    // Response to one event; updates the modelled link state
    function automatic result_t host_port_response(logic [1:0] kind, logic line,
                                                   logic [7:0] tx_byte);
        result_t r;
        r = '0;
        unique case (kind)
            FUNC_EDGE: begin
                if (link.mode == MODE_READ) begin
                    link.timer_armed = 1'b0;
                    if (link.bit_pos == 4'd0) begin
                        if (line) begin
                            r.rx_error = RXE_START;
                            drop_frame();
                        end else begin
                            link.bit_pos = 4'd1;
                            arm_timer();
                        end
                    end else if (link.bit_pos < PARITY_POS) begin
                        link.rx_shift = link.rx_shift | (8'(line) << (link.bit_pos - 4'd1));
                        link.bit_pos  = link.bit_pos + 4'd1;
                        arm_timer();
                    end else if (link.bit_pos == PARITY_POS) begin
                        // odd parity over data and parity bit
                        if ((^link.rx_shift ^ line) != 1'b1) begin
                            r.rx_error = RXE_PARITY;
                            drop_frame();
                        end else begin
                            link.bit_pos = POS_STOP;
                            arm_timer();
                        end
                    end else if (link.bit_pos == POS_STOP) begin
                        if (!line) begin
                            r.rx_error = RXE_STOP;
                        end else begin
                            r.rx_valid = 1'b1;
                            r.rx_byte  = link.rx_shift;
                        end
                        drop_frame();
                    end else begin
                        drop_frame();
                    end
                end else if (link.mode == MODE_WRITE) begin
                    if (link.bit_pos >= 4'd1 && link.bit_pos <= POS_STOP) begin
                        link.data_drive = ~link.tx_frame[link.bit_pos];
                        link.bit_pos    = link.bit_pos + 4'd1;
                        arm_timer();
                    end else if (link.bit_pos == POS_ACK) begin
                        r.tx_status = line ? TXS_FAILED : TXS_ACKED;
                        end_write();
                    end else begin
                        r.tx_status = TXS_FAILED;
                        end_write();
                    end
                end
                // edges while inhibiting are the host's own doing
            end
            FUNC_TICK: begin
                unique case (link.mode)
                    MODE_READ: begin
                        if (timer_expires(timers.read_timeout)) begin
                            r.rx_error = RXE_TIMEOUT;
                            drop_frame();
                        end
                    end
                    MODE_INHIBIT: begin
                        if (timer_expires(timers.inhibit_hold)) begin
                            // start bit on data, clock released
                            link.data_drive  = 1'b1;
                            link.clock_drive = 1'b0;
                            link.mode        = MODE_WRITE;
                            link.bit_pos     = 4'd1;
                            arm_timer();
                        end
                    end
                    default: begin
                        if (timer_expires(timers.write_timeout)) begin
                            r.tx_status = TXS_FAILED;
                            end_write();
                        end
                    end
                endcase
            end
            FUNC_WRITE: begin
                if (link.mode != MODE_READ) begin
                    r.tx_status = TXS_BUSY;
                end else begin
                    link.tx_frame = {1'b1, ~^tx_byte, tx_byte, 1'b0};
                    drop_frame();
                    link.mode        = MODE_INHIBIT;
                    link.clock_drive = 1'b1;
                    link.data_drive  = 1'b0;
                    arm_timer();
                end
            end
            default: ;
        endcase
        r.clock_pull_low = link.clock_drive;
        r.data_pull_low  = link.data_drive;
        return r;
    endfunction

    task automatic check_field(string what, int unsigned want, int unsigned seen);
        if (want != seen) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: response %0d, %s: expected 0x%0h, got 0x%0h",
                         $time, response_count, what, want, seen);
        end
    endtask

    // ---- monitor: responses first, then the event taken at the same edge ----
    always @(posedge aclk) begin : monitor
        result_t want;
        result_t seen;
        if (!aresetn) begin
            link   = '0;
            timers = {READ_TIMEOUT_RST, WRITE_TIMEOUT_RST, INHIBIT_HOLD_RST};
            due_responses.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen = result_t'(m_tdata);
                if (due_responses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response %0d arrived with none due (0x%0h)",
                                 $time, response_count, m_tdata);
                end else begin
                    want = due_responses.pop_front();
                    check_field("clock_pull_low", want.clock_pull_low, seen.clock_pull_low);
                    check_field("data_pull_low", want.data_pull_low, seen.data_pull_low);
                    check_field("rx_valid", want.rx_valid, seen.rx_valid);
                    check_field("rx_byte", want.rx_byte, seen.rx_byte);
                    check_field("rx_error", want.rx_error, seen.rx_error);
                    check_field("tx_status", want.tx_status, seen.tx_status);
                end
                response_count++;
            end
            if (s_tvalid && s_tready)
                due_responses.push_back(host_port_response(s_tuser, s_tdata[0],
                                                           s_tdata[8:1]));
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_READ_TIMEOUT:  timers.read_timeout  = cfg_wdata;
                    REG_WRITE_TIMEOUT: timers.write_timeout = cfg_wdata;
                    REG_INHIBIT_HOLD:  timers.inhibit_hold  = cfg_wdata;
                    default: ;
                endcase
            end
        end
        responses_due = due_responses.size();
    end

endmodule

// ===== tb/ps2_host_port_controller_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_host_port_controller_core_tb
// Drives PS/2 receive frames, host writes and stray events into the host port
// controller under several timer settings and idling patterns; the response
// checker beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module ps2_host_port_controller_core_tb;
    import ps2hpc_pkg::*;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         CLK_HALF       = 4;
    localparam int         STALL_LIMIT    = 20000;
    localparam int         HOLDOFF_CYCLES = 400;
    localparam int         DRAIN_CYCLES   = 8;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;
    logic [1:0]          s_tuser   = FUNC_TICK;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_index = REG_READ_TIMEOUT;
    logic [CFG_BITS-1:0] cfg_wdata = '0;

    int   mismatches;
    int   responses_due;

    // stimulus knobs and a copy of the timer limits last written
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic holdoff_req    = 1'b0;
    int   items_sent     = 0;
    int   rd_limit       = 50;
    int   wr_limit       = 2000;
    int   hold_limit     = 120;
    int   quiet_cycles   = 0;

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    ps2_host_port_controller_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ps2hpc_response_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .responses_due (responses_due)
    );

    // Watchdog: too long without any beat moving ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Response side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin : m_side
        int   hold_left;
        logic ready_next;
        if (holdoff_req) begin
            holdoff_req = 1'b0;
            hold_left   = HOLDOFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else begin
            ready_next = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
        m_tready <= ready_next;
    end

    // ---- event side ----
    // Called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so back-to-back beats never toggle it.
    task automatic offer(logic [1:0] kind, logic line, logic [7:0] tx_byte);
        int gaps;
        gaps = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gaps++;
        if (gaps != 0) begin
            s_tvalid <= 1'b0;
            repeat (gaps) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, tx_byte, line};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic ticks(int n);
        repeat (n) offer(FUNC_TICK, 1'($urandom), 8'($urandom));
    endtask

    // a zero limit expires on the first tick, like a limit of one
    function automatic int ticks_to_expire(int limit);
        return (limit == 0) ? 1 : limit;
    endfunction

    // a few ticks between edges, always short of the timeout
    task automatic gap_ticks(int limit);
        int cap;
        cap = limit - 1;
        if (cap > 3)
            cap = 3;
        if (cap > 0 && $urandom_range(2) == 0)
            ticks($urandom_range(cap));
    endtask

    // Stop driving, wait for every response, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        wait (responses_due == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic program_timers(int rt, int wt, int ih);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_READ_TIMEOUT;
        cfg_wdata <= CFG_BITS'(rt);
        @(negedge aclk);
        cfg_index <= REG_WRITE_TIMEOUT;
        cfg_wdata <= CFG_BITS'(wt);
        @(negedge aclk);
        cfg_index <= REG_INHIBIT_HOLD;
        cfg_wdata <= CFG_BITS'(ih);
        @(negedge aclk);
        cfg_we     <= 1'b0;
        rd_limit   = rt;
        wr_limit   = wt;
        hold_limit = ih;
    endtask

    // Device-to-host frame, mostly clean; some with a flaw or a stall
    task automatic receive_frame();
        logic [7:0]  value;
        logic [10:0] bits;
        int          flaw;
        int          cut;
        value = 8'($urandom);
        bits  = {1'b1, ~^value, value, 1'b0};
        flaw  = $urandom_range(11);
        cut   = $urandom_range(1, 10);
        unique case (flaw)
            0: bits[0]  = 1'b1;
            1: bits[9]  = ~bits[9];
            2: bits[10] = 1'b0;
            default: ;
        endcase
        for (int i = 0; i < 11; i++) begin
            if (flaw == 3 && i == cut && ticks_to_expire(rd_limit) <= 64) begin
                ticks(ticks_to_expire(rd_limit));
                return;
            end
            if (i != 0)
                gap_ticks(rd_limit);
            offer(FUNC_EDGE, bits[i], 8'($urandom));
        end
    endtask

    // Host-to-device write: request, inhibit, eleven device edges, the last sampling the ack
    task automatic host_write();
        int flaw;
        int cut;
        flaw = $urandom_range(9);
        cut  = $urandom_range(10);
        offer(FUNC_WRITE, 1'($urandom), 8'($urandom));
        if ($urandom_range(4) == 0)
            offer(FUNC_WRITE, 1'($urandom), 8'($urandom));
        if ($urandom_range(4) == 0)
            offer(FUNC_EDGE, 1'($urandom), 8'($urandom));
        ticks(ticks_to_expire(hold_limit));
        for (int i = 0; i < 11; i++) begin
            if (flaw == 0 && i == cut && ticks_to_expire(wr_limit) <= 64) begin
                ticks(ticks_to_expire(wr_limit));
                return;
            end
            if (flaw == 2 && i == cut)
                offer(FUNC_WRITE, 1'($urandom), 8'($urandom));
            gap_ticks(wr_limit);
            // last edge samples the device ack: low unless a nack is wanted
            offer(FUNC_EDGE, (i == 10) ? (flaw == 1) : 1'($urandom), 8'($urandom));
        end
    endtask

    task automatic random_traffic(int budget);
        int   target;
        int   pick;
        logic [1:0] kind;
        target = items_sent + budget;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                receive_frame();
            end else if (pick < 80) begin
                host_write();
            end else begin
                kind = 2'($urandom);
                if (kind == FUNC_WRITE && hold_limit > 64)
                    kind = FUNC_TICK;
                offer(kind, 1'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic run_phase(int rt, int wt, int ih, int send_pct, int stall_pct,
                             logic hold_off, int budget);
        program_timers(rt, wt, ih);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        if (hold_off)
            holdoff_req = 1'b1;
        random_traffic(budget);
    endtask

    initial begin : stimulus
        logic [10:0] frame;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: zero read and inhibit limits, idle timer, unused kind, busy, edge while
        // inhibiting, write timeout, then a clean all-ones frame
        program_timers(0, 1, 0);
        offer(FUNC_TICK, 1'b0, 8'h00);
        offer(FUNC_UNUSED, 1'b1, 8'hFF);
        offer(FUNC_EDGE, 1'b1, 8'h00);
        offer(FUNC_EDGE, 1'b0, 8'h00);
        offer(FUNC_TICK, 1'b1, 8'hFF);
        offer(FUNC_WRITE, 1'b0, 8'h00);
        offer(FUNC_WRITE, 1'b1, 8'hFF);
        offer(FUNC_EDGE, 1'b0, 8'h00);
        offer(FUNC_UNUSED, 1'b0, 8'h00);
        offer(FUNC_TICK, 1'b0, 8'h00);
        offer(FUNC_EDGE, 1'b1, 8'hFF);
        offer(FUNC_TICK, 1'b0, 8'h00);
        frame = {1'b1, ~^8'hFF, 8'hFF, 1'b0};
        for (int i = 0; i < 11; i++)
            offer(FUNC_EDGE, frame[i], 8'h00);

        // Largest read and write limits with a short inhibit, a host write, then a frame
        program_timers(16'hFFFF, 16'hFFFF, 64);
        host_write();
        receive_frame();

        // Random phases over settings and idling patterns
        run_phase(50, 2000, 120, 0, 0, 1'b0, 100);
        run_phase(4, 6, 3, 88, 0, 1'b0, 160);
        run_phase(2, 3, 1, 0, 88, 1'b0, 160);
        run_phase(1, 1, 2, 10, 10, 1'b0, 150);
        run_phase(16'hFFFF, 16'hFFFF, 4, 0, 0, 1'b1, 150);
        run_phase(3, 12, 1, 10, 10, 1'b0, 110);
        run_phase(0, 0, 0, 0, 0, 1'b0, 80);

        settle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
